[hw/rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

[hw/rtl/gwm_pkg.sv]
`default_nettype none

package gwm_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_VALUE  = 2'd2,
        OP_END    = 2'd3
    } op_t;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ANY   = 8'h3F;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // classified command handed from front to back
    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
        logic       is_star;
        logic       is_any;
        logic       not_slash;
    } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/gwm_front.sv]
`default_nettype none

module gwm_front import gwm_pkg::*; (
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_opcode,
    input  wire logic [7:0] s_character,
    input  wire logic       q_full,
    output logic            push,
    output cmd_t            push_cmd
);

    // classify the byte once so the back only does the prefix update
    always_comb begin
        push_cmd.op        = op_t'(s_opcode);
        push_cmd.ch        = s_character;
        push_cmd.is_star   = (s_character == CH_STAR);
        push_cmd.is_any    = (s_character == CH_ANY);
        push_cmd.not_slash = (s_character != CH_SLASH);
    end

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

endmodule

`default_nettype wire

[hw/rtl/gwm_queue.sv]
`default_nettype none

module gwm_queue import gwm_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/gwm_back.sv]
`default_nettype none

module gwm_back import gwm_pkg::*; #(
    parameter int PATTERN_MAX = 64
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic head_valid,
    input  wire cmd_t head_cmd,
    output logic      pop,
    output logic      m_valid,
    input  wire logic m_ready,
    output logic      m_matched,
    output logic      m_pattern_overflow
);

    localparam int VW = PATTERN_MAX + 1;
    localparam int LV = $clog2(VW);

    // pattern store, one cell per position, never cleared
    logic [7:0]             pat_ch_reg [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] pat_star_reg;
    logic [PATTERN_MAX-1:0] pat_any_reg;

    // one-hot pattern length, empty-value prefix vector, running prefix vector
    logic [VW-1:0] len_oh_reg, len_oh_next;
    logic [VW-1:0] init_reg, init_next;
    logic [VW-1:0] act_reg, act_next;
    logic          started_reg, started_next;
    logic          ovf_reg, ovf_next;
    logic          m_valid_reg, m_valid_next;
    logic          matched_reg, matched_next;
    logic          ovf_out_reg, ovf_out_next;

    logic [VW-1:0] cur_vec;
    logic          store_full;
    logic          init_last;
    logic          do_append;
    logic [VW-1:0] gen_lvl [LV+1];
    logic [VW-1:0] prp_lvl [LV+1];

    assign pop = head_valid && (head_cmd.op != OP_END || !m_valid_reg || m_ready);

    assign cur_vec    = started_reg ? act_reg : init_reg;
    assign store_full = len_oh_reg[PATTERN_MAX];
    assign init_last  = |(init_reg & len_oh_reg);
    assign do_append  = pop && head_cmd.op == OP_APPEND && !store_full;

    // per-position generate and propagate terms of the star closure
    always_comb begin
        gen_lvl[0][0] = 1'b0;
        prp_lvl[0][0] = 1'b0;
        for (int i = 1; i < VW; i++) begin
            if (pat_star_reg[i-1]) begin
                gen_lvl[0][i] = head_cmd.not_slash && cur_vec[i];
                prp_lvl[0][i] = 1'b1;
            end else if (pat_any_reg[i-1]) begin
                gen_lvl[0][i] = head_cmd.not_slash && cur_vec[i-1];
                prp_lvl[0][i] = 1'b0;
            end else begin
                gen_lvl[0][i] = (pat_ch_reg[i-1] == head_cmd.ch) && cur_vec[i-1];
                prp_lvl[0][i] = 1'b0;
            end
        end
    end

    // log-depth prefix scan resolves runs of stars
    for (genvar k = 0; k < LV; k++) begin : g_scan
        always_comb begin
            for (int i = 0; i < VW; i++) begin
                if (i >= (1 << k)) begin
                    gen_lvl[k+1][i] = gen_lvl[k][i] || (prp_lvl[k][i] && gen_lvl[k][i-(1<<k)]);
                    prp_lvl[k+1][i] = prp_lvl[k][i] && prp_lvl[k][i-(1<<k)];
                end else begin
                    gen_lvl[k+1][i] = gen_lvl[k][i];
                    prp_lvl[k+1][i] = prp_lvl[k][i];
                end
            end
        end
    end

    always_comb begin
        len_oh_next  = len_oh_reg;
        init_next    = init_reg;
        act_next     = act_reg;
        started_next = started_reg;
        ovf_next     = ovf_reg;
        matched_next = matched_reg;
        ovf_out_next = ovf_out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (pop) begin
            unique case (head_cmd.op)
                OP_CLEAR: begin
                    len_oh_next  = VW'(1);
                    init_next    = VW'(1);
                    started_next = 1'b0;
                    ovf_next     = 1'b0;
                end
                OP_APPEND: begin
                    if (store_full) begin
                        ovf_next = 1'b1;
                    end else begin
                        len_oh_next = len_oh_reg << 1;
                        init_next   = init_reg |
                                      ({VW{head_cmd.is_star && init_last}} & (len_oh_reg << 1));
                    end
                    started_next = 1'b0;
                end
                OP_VALUE: begin
                    act_next     = gen_lvl[LV];
                    started_next = 1'b1;
                end
                OP_END: begin
                    m_valid_next = 1'b1;
                    matched_next = !ovf_reg && |(cur_vec & len_oh_reg);
                    ovf_out_next = ovf_reg;
                    started_next = 1'b0;
                end
                default: begin
                    started_next = started_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_oh_reg  <= VW'(1);
            init_reg    <= VW'(1);
            act_reg     <= '0;
            started_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            len_oh_reg  <= len_oh_next;
            init_reg    <= init_next;
            act_reg     <= act_next;
            started_reg <= started_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        matched_reg <= matched_next;
        ovf_out_reg <= ovf_out_next;
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (do_append && len_oh_reg[i]) begin
                pat_ch_reg[i]   <= head_cmd.ch;
                pat_star_reg[i] <= head_cmd.is_star;
                pat_any_reg[i]  <= head_cmd.is_any;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_matched          = matched_reg;
    assign m_pattern_overflow = ovf_out_reg;

endmodule

`default_nettype wire

[hw/rtl/glob_wildcard_matcher.sv]
// throughput: one item per cycle sustained while s_ready is high, any mix of opcodes
// an end-of-value transfer waits in the queue, and its result is then registered onto m_
// while a result waits on m_ready the input keeps flowing until an end-of-value
// reaches the queue head; it and one transfer behind it fill the queue, then s_ready drops
// reset: synchronous, active low; clears the pattern length, overflow flag and queue
// pattern bytes are not cleared by reset and are only read after being appended
`default_nettype none
`include "assert_macros.svh"

module glob_wildcard_matcher import gwm_pkg::*; #(
    parameter int PATTERN_MAX = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_opcode,
    input  wire logic [7:0] s_character,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_matched,
    output logic            m_pattern_overflow
);

    // front to queue
    logic push;
    cmd_t push_cmd;
    logic q_full;

    // queue to back
    logic head_valid;
    cmd_t head_cmd;
    logic pop;

    // front: decodes the opcode and tags the byte as star, any or slash
    gwm_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_character (s_character),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // short queue decoupling the input handshake from the matcher
    gwm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // back: pattern store, prefix vector with star-closure scan, result register
    gwm_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .head_valid         (head_valid),
        .head_cmd           (head_cmd),
        .pop                (pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_matched          (m_matched),
        .m_pattern_overflow (m_pattern_overflow)
    );

    // the back only takes a command that is there
    `ASSERT_IMPLIES(a_pop_needs_head, aclk, aresetn, pop, head_valid, "pop from empty queue")

    // an end-of-value must wait while a previous result is still held on m_
    `ASSERT_IMPLIES(a_end_waits, aclk, aresetn,
        head_valid && head_cmd.op == OP_END && m_valid && !m_ready, !pop,
        "result overwritten")

    // an overflowed pattern never reports a match
    `ASSERT_IMPLIES(a_ovf_no_match, aclk, aresetn, m_valid && m_pattern_overflow, !m_matched,
        "match reported with overflow")

    // an end-of-value taken from the queue always yields a result next cycle
    `ASSERT_NEXT(a_end_gives_result, aclk, aresetn, pop && head_cmd.op == OP_END, m_valid,
        "missing result")

endmodule

`default_nettype wire
